### hdl/hamming_16_11_extract_and_pack_top_assert.svh
// Assertion macros for the extract-and-pack modules, used by h1611_pack.
`ifndef HAMMING_16_11_EXTRACT_AND_PACK_TOP_ASSERT_SVH
`define HAMMING_16_11_EXTRACT_AND_PACK_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold.
`define H1611_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define H1611_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define H1611_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define H1611_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/h1611_pkg.sv
// Types and constants for the Hamming (16,11) extract-and-pack block.
package h1611_pkg;

   localparam int DATA_BITS = 11;
   localparam int WORD_BITS = 16;
   localparam int PEND_BITS = 15;
   localparam int CNT_BITS  = 4;
   localparam int VB_BITS   = 5;
   localparam int ACC_BITS  = PEND_BITS + DATA_BITS;

   // Codeword positions that carry data, in stream order.
   localparam logic [3:0] DATA_POS [DATA_BITS] = '{
      4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
   };

   typedef struct packed {
      logic [WORD_BITS-1:0] packed_word;
      logic [VB_BITS-1:0]   valid_bits;
      logic                 message_end;
   } rsp_item_type;

   // Results of one request, handed to the response stage.
   typedef struct packed {
      logic         load;
      logic         two;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_pair_type;

endpackage

### hdl/h1611_extract.sv
// Pulls the eleven data bits out of one extended Hamming codeword.
module h1611_extract (
   input  logic [h1611_pkg::WORD_BITS-1:0] codeword,
   output logic [h1611_pkg::DATA_BITS-1:0] data_bits
);
   import h1611_pkg::*;

   // Position p sits at word bit 15-p; the first position lands in the MSB.
   for (genvar k = 0; k < DATA_BITS; k++) begin : g_bit
      assign data_bits[DATA_BITS-1-k] = codeword[4'd15 - DATA_POS[k]];
   end

endmodule

### hdl/h1611_pack.sv
// Input register, bit accumulator, results: one codeword per cycle unless stalled.
`include "hamming_16_11_extract_and_pack_top_assert.svh"

module h1611_pack (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [h1611_pkg::WORD_BITS-1:0] req_codeword,
   input  logic                            req_last,
   input  logic                            out_free,
   output h1611_pkg::rsp_pair_type         pair
);
   import h1611_pkg::*;

   logic                 in_valid_ff;
   logic [WORD_BITS-1:0] in_cw_ff;
   logic                 in_last_ff;
   logic [PEND_BITS-1:0] pend_bits_ff, pend_bits_in;
   logic [CNT_BITS-1:0]  pend_cnt_ff, pend_cnt_in;

   logic [DATA_BITS-1:0] data_bits;
   logic [ACC_BITS-1:0]  acc, acc_shift, acc_mask, acc_left;
   logic                 full, flush_need, have_res, advance;
   logic [CNT_BITS-1:0]  rem, left_cnt;
   logic [PEND_BITS-1:0] left_bits;
   logic [WORD_BITS-1:0] flush_word;
   rsp_item_type         full_res, flush_res;

   h1611_extract u_extract (
      .codeword  (in_cw_ff),
      .data_bits (data_bits)
   );

   always_comb begin
      acc        = {pend_bits_ff, data_bits};
      full       = (pend_cnt_ff >= 4'd5);
      rem        = pend_cnt_ff - 4'd5;
      acc_shift  = acc >> rem;
      acc_mask   = (ACC_BITS'(1) << rem) - ACC_BITS'(1);
      acc_left   = full ? (acc & acc_mask) : acc;
      left_bits  = acc_left[PEND_BITS-1:0];
      left_cnt   = full ? rem : (pend_cnt_ff + 4'd11);
      flush_need = in_last_ff && (left_cnt != '0);
      flush_word = WORD_BITS'({1'b0, left_bits} << (5'd16 - {1'b0, left_cnt}));

      full_res.packed_word  = acc_shift[WORD_BITS-1:0];
      full_res.valid_bits   = 5'd16;
      full_res.message_end  = in_last_ff && (left_cnt == '0);
      flush_res.packed_word = flush_word;
      flush_res.valid_bits  = {1'b0, left_cnt};
      flush_res.message_end = 1'b1;

      have_res = full || flush_need;
      advance  = in_valid_ff && (!have_res || out_free);

      pair.load   = advance && have_res;
      pair.two    = full && flush_need;
      pair.first  = full ? full_res : flush_res;
      pair.second = flush_res;

      // Drop everything after the last codeword so the next one starts afresh.
      pend_bits_in = in_last_ff ? '0 : left_bits;
      pend_cnt_in  = in_last_ff ? '0 : left_cnt;
   end

   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            pend_bits_ff <= pend_bits_in;
            pend_cnt_ff  <= pend_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cw_ff   <= req_codeword;
         in_last_ff <= req_last;
      end
   end

   `H1611_ASSERT_IMP(a_pend_clean, clock, reset, 1'b1,
      (pend_bits_ff >> pend_cnt_ff) == '0, "pending bits above count")
   `H1611_ASSERT_NXT(a_last_empties, clock, reset, advance && in_last_ff,
      pend_cnt_ff == '0, "pending bits left after last request")
   `H1611_ASSERT_IMP(a_load_free, clock, reset, pair.load, out_free,
      "results loaded into a busy response stage")

endmodule

### hdl/h1611_rsp_stage.sv
// Response register that holds up to two results and hands them out in order.
module h1611_rsp_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  h1611_pkg::rsp_pair_type             pair,
   output logic                                out_free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output h1611_pkg::rsp_item_type             rsp_item
);
   import h1611_pkg::*;

   logic         valid_ff;
   logic         two_ff;
   logic         sel_ff;
   rsp_item_type first_ff;
   rsp_item_type second_ff;
   logic         last_out;

   // The stage empties on this edge when its final result is taken.
   assign last_out   = sel_ff || !two_ff;
   assign out_free   = !valid_ff || (rsp_tready && last_out);
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = sel_ff ? second_ff : first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
         two_ff   <= 1'b0;
      end else begin
         if (pair.load) begin
            valid_ff <= 1'b1;
            sel_ff   <= 1'b0;
            two_ff   <= pair.two;
         end else if (valid_ff && rsp_tready) begin
            if (last_out) begin
               valid_ff <= 1'b0;
               sel_ff   <= 1'b0;
            end else begin
               sel_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pair.load) begin
         first_ff  <= pair.first;
         second_ff <= pair.second;
      end
   end

endmodule

### hdl/hamming_16_11_extract_and_pack_top.sv
// Top level of the extended Hamming (16,11) data extract-and-pack block.
//
//   channel   dir   tdata (low bit up)                     tlast
//   req_      in    codeword[15:0]                         is_last
//   rsp_      out   packed_word[15:0], valid_bits[20:16]   message_end
//
// One request per cycle unless the response side stalls: an accepted codeword passes
// through the input register, and its results load into the response register to be taken.
// A last codeword that completes a word and leaves a remainder yields two results; a
// following request that has a result waits while the second drains.
// Under response stall, requests without a result still pass; req_tready drops once
// the input register holds one that has a result. Reset is synchronous and empties all.
module hamming_16_11_extract_and_pack_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // codeword[15:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // packed_word[15:0], valid_bits[20:16], zero[23:21]
   output logic        rsp_tlast
);
   import h1611_pkg::*;

   rsp_pair_type pair;
   rsp_item_type rsp_item;
   logic         out_free;

   h1611_pack u_pack (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_codeword (req_tdata),
      .req_last     (req_tlast),
      .out_free     (out_free),
      .pair         (pair)
   );

   h1611_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .pair       (pair),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {3'b000, rsp_item.valid_bits, rsp_item.packed_word};
   assign rsp_tlast = rsp_item.message_end;

endmodule
